// ===== src/prg_pkg.sv =====
`timescale 1ns / 1ps
package prg_pkg;
    localparam int PIX_W   = 16;
    localparam int EXT_W   = 24;
    localparam int ROT_W   = 16;
    localparam int EYE_W   = 32;
    localparam int DIR_W   = 16;
    localparam int MAG_W   = 30;
    localparam int ROOT_W  = 31;
    localparam int Q_W     = 15;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_HALF_W = 3'd0;
    localparam logic [IDX_W-1:0] REG_HALF_H = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROT0   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROT1   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROT2   = 3'd4;
    localparam logic [IDX_W-1:0] REG_EYE_X  = 3'd5;
    localparam logic [IDX_W-1:0] REG_EYE_Y  = 3'd6;
    localparam logic [IDX_W-1:0] REG_EYE_Z  = 3'd7;

    localparam logic [DIR_W-1:0] DIR_ONE = 16'd16384;

    typedef struct packed {
        logic [EXT_W-1:0]                 half_width;
        logic [EXT_W-1:0]                 half_height;
        logic [2:0][2:0][ROT_W-1:0]       rot;
        logic [2:0][EYE_W-1:0]            eye;
    } t_cfg;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } t_vec;
endpackage

// ===== src/prg_in_if.sv =====
`timescale 1ns / 1ps
interface prg_in_if;
    import prg_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_u;
    logic [PIX_W-1:0] pixel_v;
    modport source(output valid, pixel_u, pixel_v, input ready);
    modport sink(input valid, pixel_u, pixel_v, output ready);
endinterface

// ===== src/prg_out_if.sv =====
`timescale 1ns / 1ps
interface prg_out_if;
    import prg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [EYE_W-1:0] origin_x;
    logic signed [EYE_W-1:0] origin_y;
    logic signed [EYE_W-1:0] origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
    modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

// ===== src/prg_cfg.sv =====
`timescale 1ns / 1ps
module prg_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prg_pkg::ADDR_W-1:0]  paddr,
    input  logic [prg_pkg::DATA_W-1:0]  pwdata,
    output logic [prg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output prg_pkg::t_cfg               o_cfg
);
    import prg_pkg::*;

    logic [EXT_W-1:0]   r_half_w, r_half_h;
    logic [3*ROT_W-1:0] r_rot0, r_rot1, r_rot2;
    logic [EYE_W-1:0]   r_eye_x, r_eye_y, r_eye_z;
    logic [IDX_W-1:0]   idx;

    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= 24'd65536;
            r_half_h <= 24'd65536;
            r_rot0   <= 48'd16384;
            r_rot1   <= 48'd16384 << 16;
            r_rot2   <= 48'd16384 << 32;
            r_eye_x  <= '0;
            r_eye_y  <= '0;
            r_eye_z  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                REG_HALF_W: r_half_w <= pwdata[EXT_W-1:0];
                REG_HALF_H: r_half_h <= pwdata[EXT_W-1:0];
                REG_ROT0:   r_rot0   <= pwdata[3*ROT_W-1:0];
                REG_ROT1:   r_rot1   <= pwdata[3*ROT_W-1:0];
                REG_ROT2:   r_rot2   <= pwdata[3*ROT_W-1:0];
                REG_EYE_X:  r_eye_x  <= pwdata[EYE_W-1:0];
                REG_EYE_Y:  r_eye_y  <= pwdata[EYE_W-1:0];
                REG_EYE_Z:  r_eye_z  <= pwdata[EYE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_HALF_W: prdata = DATA_W'(r_half_w);
            REG_HALF_H: prdata = DATA_W'(r_half_h);
            REG_ROT0:   prdata = DATA_W'(r_rot0);
            REG_ROT1:   prdata = DATA_W'(r_rot1);
            REG_ROT2:   prdata = DATA_W'(r_rot2);
            REG_EYE_X:  prdata = DATA_W'(r_eye_x);
            REG_EYE_Y:  prdata = DATA_W'(r_eye_y);
            REG_EYE_Z:  prdata = DATA_W'(r_eye_z);
        endcase
    end

    always_comb begin
        o_cfg.half_width  = r_half_w;
        o_cfg.half_height = r_half_h;
        for (int c = 0; c < 3; c++) begin
            o_cfg.rot[0][c] = r_rot0[ROT_W*c +: ROT_W];
            o_cfg.rot[1][c] = r_rot1[ROT_W*c +: ROT_W];
            o_cfg.rot[2][c] = r_rot2[ROT_W*c +: ROT_W];
        end
        o_cfg.eye[0] = r_eye_x;
        o_cfg.eye[1] = r_eye_y;
        o_cfg.eye[2] = r_eye_z;
    end
endmodule

// ===== src/prg_front.sv =====
`timescale 1ns / 1ps
module prg_front #(
    parameter int PIXEL_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  prg_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [prg_pkg::PIX_W-1:0]  i_pixel_u,
    input  logic [prg_pkg::PIX_W-1:0]  i_pixel_v,
    output logic                       o_valid,
    input  logic                       i_ready,
    output prg_pkg::t_vec              o_vec
);
    import prg_pkg::*;

    localparam int P   = PIXEL_FRAC_BITS;
    localparam int SW  = ((P > PIX_W + 1) ? P : PIX_W + 1) + 2;
    localparam int PW  = EXT_W + 1 + SW;
    localparam int VW  = PW - P;
    localparam int DW  = VW + ROT_W + 2;
    localparam int NC  = (DW + 7) / 8;
    localparam int PSW = $clog2(8 * NC);
    localparam int NS  = 7;
    localparam logic signed [SW-1:0] S_OFF    = SW'(1) << P;
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (P - 1);
    localparam logic signed [VW-1:0] Z_CAM    = -VW'(65536);
    localparam logic [PSW-1:0]       NORM_POS = PSW'(MAG_W - 1);

    logic [NS-1:0] r_v;
    logic [NS-1:0] stg_en;

    // stage 0: extent products
    logic signed [PW-1:0] r_pu, r_pv, n_pu, n_pv;
    logic signed [SW-1:0] su, sv;
    // stage 1: camera-space x, y
    logic signed [VW-1:0] r_vx, r_vy, n_vx, n_vy;
    logic signed [PW-1:0] tu, tv;
    // stage 2: rotation products
    logic signed [VW+ROT_W-1:0] r_p [3][3];
    logic signed [VW+ROT_W-1:0] n_p [3][3];
    logic signed [VW-1:0]       vv [3];
    // stage 3: magnitudes
    logic [DW-1:0] r_mag3 [3];
    logic [DW-1:0] n_mag3 [3];
    logic [2:0]    r_neg3, n_neg3;
    logic [DW-1:0] r_or, n_or;
    logic signed [DW-1:0] d;
    // stage 4: per-byte leading one
    logic [DW-1:0]  r_mag4 [3];
    logic [2:0]     r_neg4;
    logic [NC-1:0]  r_cnz, n_cnz;
    logic [2:0]     r_cpos [NC];
    logic [2:0]     n_cpos [NC];
    logic [8*NC-1:0] or_pad;
    // stage 5: leading one position
    logic [DW-1:0]  r_mag5 [3];
    logic [2:0]     r_neg5;
    logic [PSW-1:0] r_pos, n_pos;
    logic           r_zero5, n_zero5;
    // stage 6: normalized vector
    t_vec r_vec, n_vec;
    logic [DW-1:0]       sr;
    logic [DW+MAG_W-1:0] sl;

    always_comb begin
        stg_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
    end
    assign o_ready = stg_en[0];
    assign o_valid = r_v[NS-1];
    assign o_vec   = r_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        su = $signed({{(SW-PIX_W-1){1'b0}}, i_pixel_u, 1'b0}) - S_OFF;
        sv = $signed({{(SW-PIX_W-1){1'b0}}, i_pixel_v, 1'b0}) - S_OFF;
        n_pu = $signed({1'b0, i_cfg.half_width}) * su;
        n_pv = $signed({1'b0, i_cfg.half_height}) * sv;

        tu = r_pu + HALF_LSB;
        tv = r_pv + HALF_LSB;
        n_vx = VW'(tu >>> P);
        n_vy = VW'(tv >>> P);

        vv[0] = r_vx;
        vv[1] = r_vy;
        vv[2] = Z_CAM;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_p[r][c] = $signed(i_cfg.rot[r][c]) * vv[c];
            end
        end

        n_or = '0;
        for (int r = 0; r < 3; r++) begin
            d = DW'(r_p[r][0]) + DW'(r_p[r][1]) + DW'(r_p[r][2]);
            n_neg3[r] = d[DW-1];
            n_mag3[r] = d[DW-1] ? DW'(-d) : DW'(d);
            n_or = n_or | n_mag3[r];
        end

        // msb of the max equals msb of the OR of all magnitudes
        or_pad = (8*NC)'(r_or);
        for (int c = 0; c < NC; c++) begin
            n_cnz[c]  = |or_pad[8*c +: 8];
            n_cpos[c] = '0;
            for (int b = 0; b < 8; b++) begin
                if (or_pad[8*c + b]) n_cpos[c] = 3'(b);
            end
        end

        n_pos = '0;
        for (int c = 0; c < NC; c++) begin
            if (r_cnz[c]) n_pos = PSW'(8 * c) + PSW'(r_cpos[c]);
        end
        n_zero5 = !(|r_cnz);

        n_vec.neg  = r_neg5;
        n_vec.zero = r_zero5;
        for (int i = 0; i < 3; i++) begin
            sr = r_mag5[i] >> (r_pos - NORM_POS);
            sl = {{MAG_W{1'b0}}, r_mag5[i]} << (NORM_POS - r_pos);
            n_vec.mag[i] = (r_pos >= NORM_POS) ? sr[MAG_W-1:0] : sl[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_pu <= n_pu;
            r_pv <= n_pv;
        end
        if (stg_en[1]) begin
            r_vx <= n_vx;
            r_vy <= n_vy;
        end
        if (stg_en[2]) r_p <= n_p;
        if (stg_en[3]) begin
            r_mag3 <= n_mag3;
            r_neg3 <= n_neg3;
            r_or   <= n_or;
        end
        if (stg_en[4]) begin
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            r_cnz  <= n_cnz;
            r_cpos <= n_cpos;
        end
        if (stg_en[5]) begin
            r_mag5  <= r_mag4;
            r_neg5  <= r_neg4;
            r_pos   <= n_pos;
            r_zero5 <= n_zero5;
        end
        if (stg_en[6]) r_vec <= n_vec;
    end
endmodule

// ===== src/prg_sqrt.sv =====
`timescale 1ns / 1ps
module prg_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  prg_pkg::t_vec               i_vec,
    output logic                        o_valid,
    input  logic                        i_ready,
    output prg_pkg::t_vec               o_vec,
    output logic [prg_pkg::ROOT_W-1:0]  o_root
);
    import prg_pkg::*;

    localparam int SQ_W = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int NIT = ROOT_W + 1;
    localparam int IPS = 2;
    localparam int NSQ = NIT / IPS;
    localparam int NS  = NSQ + 2;
    localparam int XW  = 64;

    logic [NS-1:0] r_v;
    logic [NS-1:0] stg_en;
    t_vec          r_vec [NS];
    logic [SQ_W-1:0]  r_sq [3];
    logic [SQ_W-1:0]  n_sq [3];
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [XW-1:0] r_x [NSQ];
    logic [XW-1:0] r_r [NSQ];
    logic [XW-1:0] n_x [NSQ];
    logic [XW-1:0] n_r [NSQ];
    logic [XW-1:0] x, rt, b;

    always_comb begin
        stg_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
    end
    assign o_ready = stg_en[0];
    assign o_valid = r_v[NS-1];
    assign o_vec   = r_vec[NS-1];
    assign o_root  = r_r[NSQ-1][ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stg_en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    // digit-by-digit square root, two result bits per stage
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = i_vec.mag[i] * i_vec.mag[i];
        end
        n_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        for (int s = 0; s < NSQ; s++) begin
            x  = (s == 0) ? XW'(r_sum) : r_x[s-1];
            rt = (s == 0) ? '0 : r_r[s-1];
            for (int j = 0; j < IPS; j++) begin
                b = XW'(1) << (2 * (NIT - 1 - (s * IPS + j)));
                if (x >= rt + b) begin
                    x  = x - (rt + b);
                    rt = (rt >> 1) + b;
                end else begin
                    rt = rt >> 1;
                end
            end
            n_x[s] = x;
            n_r[s] = rt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_sq     <= n_sq;
            r_vec[0] <= i_vec;
        end
        if (stg_en[1]) begin
            r_sum    <= n_sum;
            r_vec[1] <= r_vec[0];
        end
        for (int s = 0; s < NSQ; s++) begin
            if (stg_en[s+2]) begin
                r_x[s]     <= n_x[s];
                r_r[s]     <= n_r[s];
                r_vec[s+2] <= r_vec[s+1];
            end
        end
    end
endmodule

// ===== src/prg_div.sv =====
`timescale 1ns / 1ps
module prg_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  prg_pkg::t_vec                      i_vec,
    input  logic [prg_pkg::ROOT_W-1:0]         i_root,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0][prg_pkg::DIR_W-1:0]     o_dir
);
    import prg_pkg::*;

    localparam int QPS   = 3;
    localparam int NDS   = Q_W / QPS;
    localparam int NS    = NDS + 2;
    localparam int REM_W = ROOT_W + Q_W;
    localparam logic [ROOT_W-1:0] N_MIN = ROOT_W'(1) << (MAG_W - 1);

    logic [NS-1:0] r_v;
    logic [NS-1:0] stg_en;
    logic [REM_W-1:0]  r_rem [NDS+1][3];
    logic [REM_W-1:0]  n_rem [NDS+1][3];
    logic [Q_W-1:0]    r_q   [NDS+1][3];
    logic [Q_W-1:0]    n_q   [NDS+1][3];
    logic [ROOT_W-1:0] r_n   [NDS+1];
    logic [2:0]        r_neg [NDS+1];
    logic              r_zero [NDS+1];
    logic [2:0][DIR_W-1:0] r_dir, n_dir;
    logic [REM_W-1:0] rem, tv;
    logic [Q_W-1:0]   q;
    logic [DIR_W-1:0] qc;
    int               jb;

    always_comb begin
        stg_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
    end
    assign o_ready = stg_en[0];
    assign o_valid = r_v[NS-1];
    assign o_dir   = r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stg_en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    // restoring division, three quotient bits per stage; rounding is folded
    // into the dividend as half the divisor
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_rem[0][l] = REM_W'({i_vec.mag[l], {(Q_W-1){1'b0}}}) + REM_W'(i_root >> 1);
            n_q[0][l]   = '0;
        end
        for (int s = 1; s <= NDS; s++) begin
            for (int l = 0; l < 3; l++) begin
                rem = r_rem[s-1][l];
                q   = r_q[s-1][l];
                for (int t = 0; t < QPS; t++) begin
                    jb = Q_W - 1 - ((s - 1) * QPS + t);
                    tv = REM_W'(r_n[s-1]) << jb;
                    if (rem >= tv) begin
                        rem   = rem - tv;
                        q[jb] = 1'b1;
                    end
                end
                n_rem[s][l] = rem;
                n_q[s][l]   = q;
            end
        end
        for (int l = 0; l < 3; l++) begin
            qc = DIR_W'(r_q[NDS][l]);
            if (qc > DIR_ONE) qc = DIR_ONE;
            if (r_zero[NDS])        n_dir[l] = '0;
            else if (r_neg[NDS][l]) n_dir[l] = -qc;
            else                    n_dir[l] = qc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_rem[0]  <= n_rem[0];
            r_q[0]    <= n_q[0];
            r_n[0]    <= i_root;
            r_neg[0]  <= i_vec.neg;
            r_zero[0] <= i_vec.zero;
        end
        for (int s = 1; s <= NDS; s++) begin
            if (stg_en[s]) begin
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= n_q[s];
                r_n[s]    <= r_n[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end
        if (stg_en[NS-1]) r_dir <= n_dir;
    end

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_vec.zero) |-> (i_root >= N_MIN))
        else $error("root below normalized range");

    a_root_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_vec.zero) |->
        (ROOT_W'(i_vec.mag[0]) <= i_root && ROOT_W'(i_vec.mag[1]) <= i_root &&
         ROOT_W'(i_vec.mag[2]) <= i_root))
        else $error("component magnitude exceeds root");

    a_quot_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NDS] && !r_zero[NDS]) |->
        (DIR_W'(r_q[NDS][0]) <= DIR_ONE && DIR_W'(r_q[NDS][1]) <= DIR_ONE &&
         DIR_W'(r_q[NDS][2]) <= DIR_ONE))
        else $error("quotient above unit length");
endmodule

// ===== src/primary_ray_generation.sv =====
`timescale 1ns / 1ps
// Pinhole camera primary ray generator. Each pixel beat (u, v) yields one ray
// beat: origin is the eye register, direction is the unit vector of
// rotation * (half_width*(2u-1), half_height*(2v-1), -1) in Q2.14. A new pixel
// is taken every cycle while no stall reaches the input; the pipeline has 7 front-end stages for the
// extent and rotation multiplies and normalizing shift, 18 for the squares
// and the two-bits-per-stage square root, and 7 for the three parallel restoring
// dividers and the output register. Stalls hold per stage, bubbles collapse.
// Registers sit on a 64-bit APB port at byte address 8*index.
module primary_ray_generation #(
    parameter int PIXEL_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prg_pkg::ADDR_W-1:0]  paddr,
    input  logic [prg_pkg::DATA_W-1:0]  pwdata,
    output logic [prg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    prg_in_if.sink                      i_pix,
    prg_out_if.source                   o_ray
);
    import prg_pkg::*;

    t_cfg  cfg;
    t_vec  f_vec, s_vec;
    logic  f_valid, f_ready, s_valid, s_ready;
    logic [ROOT_W-1:0]     s_root;
    logic [2:0][DIR_W-1:0] dir;

    prg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    prg_front #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_pix.valid),
        .o_ready   (i_pix.ready),
        .i_pixel_u (i_pix.pixel_u),
        .i_pixel_v (i_pix.pixel_v),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_vec     (f_vec)
    );

    prg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_vec   (f_vec),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_vec   (s_vec),
        .o_root  (s_root)
    );

    prg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_ready (s_ready),
        .i_vec   (s_vec),
        .i_root  (s_root),
        .o_valid (o_ray.valid),
        .i_ready (o_ray.ready),
        .o_dir   (dir)
    );

    // user must change eye only while idle, not enforced; origin is the register
    assign o_ray.origin_x = cfg.eye[0];
    assign o_ray.origin_y = cfg.eye[1];
    assign o_ray.origin_z = cfg.eye[2];
    assign o_ray.dir_x    = dir[0];
    assign o_ray.dir_y    = dir[1];
    assign o_ray.dir_z    = dir[2];
endmodule

// ===== tb/primary_ray_generation_tb.sv =====
`timescale 1ns / 1ps
module primary_ray_generation_tb;
    import prg_pkg::*;

    typedef struct {
        logic signed [EYE_W-1:0] org[3];
        logic signed [DIR_W-1:0] dir[3];
    } t_ray;

    class ray_scoreboard;
        bit [EXT_W-1:0] half_w;
        bit [EXT_W-1:0] half_h;
        bit [47:0]      rot_row[3];
        bit [EYE_W-1:0] eye[3];
        t_ray           ray_q[$];
        int             mismatches;
        int             orphans;

        function void load_defaults();
            half_w = 24'd65536;
            half_h = 24'd65536;
            rot_row[0] = 48'd16384;
            rot_row[1] = 48'd16384 << 16;
            rot_row[2] = 48'd16384 << 32;
            foreach (eye[i]) eye[i] = '0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                REG_HALF_W: half_w = val[23:0];
                REG_HALF_H: half_h = val[23:0];
                REG_ROT0:   rot_row[0] = val[47:0];
                REG_ROT1:   rot_row[1] = val[47:0];
                REG_ROT2:   rot_row[2] = val[47:0];
                REG_EYE_X:  eye[0] = val[31:0];
                REG_EYE_Y:  eye[1] = val[31:0];
                REG_EYE_Z:  eye[2] = val[31:0];
                default: ;
            endcase
        endfunction

        // floor((ext * (2p - 1)) + half) in Q8.16
        function longint cam_term(bit [EXT_W-1:0] ext, bit [PIX_W-1:0] p);
            longint s;
            longint prod;
            s = 2 * longint'(p) - 65536;
            prod = longint'(ext) * s + 32768;
            return prod >>> 16;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_pixel(bit [PIX_W-1:0] u, bit [PIX_W-1:0] v);
            longint          cv[3];
            longint          d[3];
            longint unsigned mag[3];
            longint unsigned m;
            longint unsigned n;
            longint unsigned q;
            t_ray            r;
            cv[0] = cam_term(half_w, u);
            cv[1] = cam_term(half_h, v);
            cv[2] = -65536;
            m = 0;
            for (int i = 0; i < 3; i++) begin
                d[i] = longint'($signed(rot_row[i][15:0])) * cv[0]
                     + longint'($signed(rot_row[i][31:16])) * cv[1]
                     + longint'($signed(rot_row[i][47:32])) * cv[2];
                mag[i] = d[i] < 0 ? -d[i] : d[i];
                if (mag[i] > m) m = mag[i];
                r.org[i] = eye[i];
                r.dir[i] = '0;
            end
            if (m != 0) begin
                while (m >= (64'd1 << 30)) begin
                    foreach (mag[i]) mag[i] >>= 1;
                    m >>= 1;
                end
                while (m < (64'd1 << 29)) begin
                    foreach (mag[i]) mag[i] <<= 1;
                    m <<= 1;
                end
                n = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
                for (int i = 0; i < 3; i++) begin
                    q = ((mag[i] << 14) + (n >> 1)) / n;
                    if (q > 16384) q = 16384;
                    r.dir[i] = d[i] < 0 ? -q[15:0] : q[15:0];
                end
            end
            ray_q.push_back(r);
        endfunction

        function void check_ray(t_ray got);
            t_ray exp_r;
            bit   bad;
            if (ray_q.size() == 0) begin
                orphans++;
                $display("unexpected ray beat at %0t", $realtime);
                return;
            end
            exp_r = ray_q.pop_front();
            bad = 0;
            for (int i = 0; i < 3; i++) begin
                if (got.org[i] !== exp_r.org[i] || got.dir[i] !== exp_r.dir[i]) bad = 1;
            end
            if (bad) begin
                if (mismatches < 10)
                    $display({"ray mismatch at %0t: exp org %0d %0d %0d dir %0d %0d %0d,",
                              " got org %0d %0d %0d dir %0d %0d %0d"},
                             $realtime, exp_r.org[0], exp_r.org[1], exp_r.org[2],
                             exp_r.dir[0], exp_r.dir[1], exp_r.dir[2],
                             got.org[0], got.org[1], got.org[2],
                             got.dir[0], got.dir[1], got.dir[2]);
                mismatches++;
            end
        endfunction
    endclass

    localparam int LATENCY   = 32;
    localparam int CYC_LIMIT = 400000;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                psel = 0;
    logic                penable = 0;
    logic                pwrite = 0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    prg_in_if  pix();
    prg_out_if ray();

    primary_ray_generation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_pix(pix), .o_ray(ray)
    );

    ray_scoreboard sb = new();
    int  cycles = 0;
    bit  long_hold = 0;
    int  stall_left = 0;

    always #1 i_clk = ~i_clk;

    initial begin
        pix.valid = 0;
        pix.pixel_u = '0;
        pix.pixel_v = '0;
        ray.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // monitors: sample pre-edge values
    always @(posedge i_clk) begin
        t_ray got;
        if (i_rst_n && pix.valid && pix.ready) sb.note_pixel(pix.pixel_u, pix.pixel_v);
        if (i_rst_n && ray.valid && ray.ready) begin
            got.org[0] = ray.origin_x;
            got.org[1] = ray.origin_y;
            got.org[2] = ray.origin_z;
            got.dir[0] = ray.dir_x;
            got.dir[1] = ray.dir_y;
            got.dir[2] = ray.dir_z;
            sb.check_ray(got);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (long_hold) begin
            long_hold <= 0;
            stall_left <= 300;
            ray.ready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            ray.ready <= 0;
        end else if ($urandom_range(0, 99) < 12) begin
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 3);
            ray.ready <= 0;
        end else begin
            ray.ready <= 1;
        end
    end

    task automatic reg_write(logic [IDX_W-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] u, logic [PIX_W-1:0] v, bit bursty);
        int gap;
        pix.valid <= 1;
        pix.pixel_u <= u;
        pix.pixel_v <= v;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        gap = 0;
        if (bursty) begin
            if ($urandom_range(0, 99) < 25) gap = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 3) gap = $urandom_range(15, 50);
        end
        if (gap > 0) begin
            pix.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        pix.valid <= 0;
        while (sb.ray_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_rot_row(int kind, int axis);
        logic [15:0] e[3];
        foreach (e[i]) e[i] = '0;
        case (kind)
            0: e[axis] = $urandom_range(0, 1) ? 16'd16384 : -16'sd16384;
            1: foreach (e[i]) e[i] = $urandom();
            default: foreach (e[i]) e[i] = $urandom_range(0, 1023) - 512;
        endcase
        return {e[2], e[1], e[0]};
    endfunction

    task automatic random_config(int ph);
        int kind;
        int perm;
        kind = ph % 3;
        perm = $urandom_range(0, 2);
        if (ph == 1) begin
            reg_write(REG_HALF_W, '0);
            reg_write(REG_HALF_H, 64'hFFFFFF);
        end else if (ph == 2) begin
            reg_write(REG_HALF_W, 64'hFFFFFF);
            reg_write(REG_HALF_H, '0);
        end else begin
            reg_write(REG_HALF_W, {$urandom(), $urandom()} & (ph % 4 == 0 ? 64'hFFFFFF
                                                                   : 64'h3FFFF));
            reg_write(REG_HALF_H, {$urandom(), $urandom()} & (ph % 4 == 0 ? 64'hFFFFFF
                                                                   : 64'h3FFFF));
        end
        reg_write(REG_ROT0, rand_rot_row(kind, perm));
        reg_write(REG_ROT1, rand_rot_row(kind, (perm + 1) % 3));
        reg_write(REG_ROT2, rand_rot_row(kind, (perm + 2) % 3));
        reg_write(REG_EYE_X, {$urandom(), $urandom()});
        reg_write(REG_EYE_Y, ph == 1 ? 64'h80000000 : {$urandom(), $urandom()});
        reg_write(REG_EYE_Z, ph == 1 ? 64'h7FFFFFFF : {$urandom(), $urandom()});
    endtask

    logic [PIX_W-1:0] corners[5] = '{16'd0, 16'd1, 16'd32768, 16'd65534, 16'd65535};

    initial begin
        sb.load_defaults();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset config, image corners and center
        foreach (corners[i]) begin
            foreach (corners[j]) begin
                if ((i + j) % 2 == 0) send_pixel(corners[i], corners[j], 0);
            end
        end
        drain();

        // degenerate rotation: zero vector
        reg_write(REG_ROT0, '0);
        reg_write(REG_ROT1, '0);
        reg_write(REG_ROT2, '0);
        send_pixel(16'd0, 16'd65535, 0);
        send_pixel(16'd32768, 16'd32768, 0);
        drain();

        for (int ph = 1; ph <= 8; ph++) begin
            random_config(ph);
            if (ph == 4) long_hold <= 1;
            for (int k = 0; k < 178; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)],
                               ph != 4);
                else
                    send_pixel($urandom(), $urandom(), ph != 4);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.orphans == 0 && sb.ray_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
